// File: src/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

   typedef enum logic [1:0] {
      CMD_PUT   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_TAB       = 8'd9;
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_RETURN    = 8'd13;
   localparam logic [7:0] BLANK_CHAR   = 8'h20;
   localparam logic [7:0] RESET_COLOR  = 8'h07;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] char_code;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } req_type;

   typedef struct packed {
      logic [4:0] cursor_row;
      logic [6:0] cursor_col;
      logic [7:0] cell_char;
      logic [7:0] cell_attr;
   } rsp_type;

   typedef struct packed {
      logic write;
      logic blank;
      logic scroll;
   } cursor_ctl_type;

endpackage

// File: src/text_console_cell_writer.sv
`timescale 1ns / 1ps

// Text console engine with a screen of 16-bit cells and a cursor.
// Request beats carry a command (put character, clear screen, read cell), a
// character byte and a read position; each request beat gives exactly one
// response beat with the cursor position after the command and, for a read,
// the cell's character and attribute bytes (zero otherwise).
// The attribute byte for stored characters and blanks comes from the CSR
// port, written with csr_write_enable; the user must write it only while
// the engine is idle, which the block itself does not enforce.
// A put without scroll has its response registered at acceptance; a read
// of a cell on the screen goes through the registered read port of the cell
// store and the ST_READ state first, and a read outside it is answered at
// acceptance. A put that runs past the last row scrolls the screen: each
// row is copied up one row, then the bottom row is blanked. A clear blanks
// the whole screen, one cell written a cycle. After reset the store is
// filled with blanks of attribute 0x07, during which req_ready stays low.
// The response sits in an output register; while rsp_ready is low it holds
// and no new request beat is taken, and a new beat may be taken in the
// cycle in which the waiting response is taken.
module text_console_cell_writer
   import tcw_pkg::*;
#(
   parameter int COLUMNS  = 80,
   parameter int ROWS     = 25,
   parameter int TAB_STOP = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_payload,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int AW    = RW + CW;
   localparam int DEPTH = ROWS * (2 ** CW);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_READ   = 5'b00010,
      ST_SCROLL = 5'b00100,
      ST_FILL   = 5'b01000,
      ST_SPARE  = 5'b10000
   } state_type;

   state_type      state_ff, state_in;
   logic [7:0]     color_ff;
   logic [7:0]     fill_attr_ff, fill_attr_in;
   logic [RW-1:0]  cnt_row_ff, cnt_row_in;
   logic [CW-1:0]  cnt_col_ff, cnt_col_in;
   logic           copy_valid_ff, copy_valid_in;
   logic [AW-1:0]  copy_addr_ff, copy_addr_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   logic [15:0]    mem [DEPTH];
   logic [15:0]    rdata_ff;
   logic           mem_we;
   logic [AW-1:0]  mem_waddr;
   logic [15:0]    mem_wdata;
   logic [AW-1:0]  mem_raddr;

   logic           accept;
   logic           is_put, is_clear;
   logic           read_inside;
   logic [RW-1:0]  cur_row, cur_col_unused_row;
   logic [CW-1:0]  cur_col;
   logic [RW-1:0]  nxt_row;
   logic [CW-1:0]  nxt_col;
   logic [CW-1:0]  put_col;
   cursor_ctl_type put_ctl;
   logic           last_col;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign is_put    = accept && (req_payload.command == CMD_PUT);
   assign is_clear  = accept && (req_payload.command == CMD_CLEAR);
   assign read_inside = (32'(req_payload.read_row) < ROWS) &&
                        (32'(req_payload.read_col) < COLUMNS);
   assign last_col  = (cnt_col_ff == CW'(COLUMNS - 1));
   assign cur_col_unused_row = cur_row;

   tcw_cursor #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_STOP (TAB_STOP)
   ) u_cursor (
      .clock     (clock),
      .reset     (reset),
      .put_en    (is_put),
      .clear_en  (is_clear),
      .char_code (req_payload.char_code),
      .row       (cur_row),
      .col       (cur_col),
      .next_row  (nxt_row),
      .next_col  (nxt_col),
      .cell_col  (put_col),
      .ctl       (put_ctl)
   );

   always_comb begin
      state_in      = state_ff;
      fill_attr_in  = fill_attr_ff;
      cnt_row_in    = cnt_row_ff;
      cnt_col_in    = cnt_col_ff;
      copy_valid_in = 1'b0;
      copy_addr_in  = copy_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_waddr     = copy_addr_ff;
      mem_wdata     = rdata_ff;
      mem_raddr     = {cnt_row_ff + RW'(1), cnt_col_ff};
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               rsp_in.cursor_row = 5'(cur_col_unused_row);
               rsp_in.cursor_col = 7'(cur_col);
               unique case (req_payload.command)
                  CMD_PUT: begin
                     rsp_in.cursor_row = 5'(nxt_row);
                     rsp_in.cursor_col = 7'(nxt_col);
                     mem_we    = put_ctl.write;
                     mem_waddr = {cur_row, put_col};
                     mem_wdata = put_ctl.blank ? {color_ff, BLANK_CHAR}
                                               : {color_ff, req_payload.char_code};
                     if (put_ctl.scroll) begin
                        state_in     = ST_SCROLL;
                        fill_attr_in = color_ff;
                        cnt_row_in   = '0;
                        cnt_col_in   = '0;
                     end
                  end
                  CMD_CLEAR: begin
                     rsp_in.cursor_row = '0;
                     rsp_in.cursor_col = '0;
                     state_in     = ST_FILL;
                     fill_attr_in = color_ff;
                     cnt_row_in   = '0;
                     cnt_col_in   = '0;
                  end
                  CMD_READ: begin
                     mem_raddr = {RW'(req_payload.read_row), CW'(req_payload.read_col)};
                     if (read_inside) begin
                        rsp_valid_in = 1'b0;
                        state_in     = ST_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in     = 1'b1;
            rsp_in           = '0;
            rsp_in.cursor_row = 5'(cur_row);
            rsp_in.cursor_col = 7'(cur_col);
            rsp_in.cell_char = rdata_ff[7:0];
            rsp_in.cell_attr = rdata_ff[15:8];
            state_in         = ST_IDLE;
         end
         ST_SCROLL: begin
            mem_we        = copy_valid_ff;
            copy_valid_in = 1'b1;
            copy_addr_in  = {cnt_row_ff, cnt_col_ff};
            if (last_col) begin
               cnt_col_in = '0;
               if (cnt_row_ff == RW'(ROWS - 2)) begin
                  state_in   = ST_FILL;
                  cnt_row_in = RW'(ROWS - 1);
               end else begin
                  cnt_row_in = cnt_row_ff + RW'(1);
               end
            end else begin
               cnt_col_in = cnt_col_ff + CW'(1);
            end
         end
         ST_FILL: begin
            mem_we = 1'b1;
            if (!copy_valid_ff) begin
               mem_waddr = {cnt_row_ff, cnt_col_ff};
               mem_wdata = {fill_attr_ff, BLANK_CHAR};
               if (last_col) begin
                  cnt_col_in = '0;
                  if (cnt_row_ff == RW'(ROWS - 1)) begin
                     state_in = ST_IDLE;
                  end else begin
                     cnt_row_in = cnt_row_ff + RW'(1);
                  end
               end else begin
                  cnt_col_in = cnt_col_ff + CW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_FILL;
         color_ff      <= RESET_COLOR;
         fill_attr_ff  <= RESET_COLOR;
         cnt_row_ff    <= '0;
         cnt_col_ff    <= '0;
         copy_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_attr_ff  <= fill_attr_in;
         cnt_row_ff    <= cnt_row_in;
         cnt_col_ff    <= cnt_col_in;
         copy_valid_ff <= copy_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_enable) begin
            color_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      copy_addr_ff <= copy_addr_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_scroll_start: assert property (@(posedge clock) disable iff (reset)
      (is_put && put_ctl.scroll) |=> (state_ff == ST_SCROLL))
      else $error("scroll not started after a put past the last row");

   a_read_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (!mem_we && !rsp_valid_ff))
      else $error("cell store written or response pending during a read");

   a_copy_phase: assert property (@(posedge clock) disable iff (reset)
      copy_valid_ff |-> ((state_ff == ST_SCROLL) || (state_ff == ST_FILL)))
      else $error("pending row copy outside scroll");

   a_scroll_rows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCROLL) |-> (32'(cnt_row_ff) < ROWS - 1))
      else $error("scroll source row beyond the screen");

endmodule

// File: src/tcw_cursor.sv
`timescale 1ns / 1ps

module tcw_cursor
   import tcw_pkg::*;
#(
   parameter int COLUMNS  = 80,
   parameter int ROWS     = 25,
   parameter int TAB_STOP = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         put_en,
   input  logic                         clear_en,
   input  logic [7:0]                   char_code,
   output logic [$clog2(ROWS)-1:0]      row,
   output logic [$clog2(COLUMNS)-1:0]   col,
   output logic [$clog2(ROWS)-1:0]      next_row,
   output logic [$clog2(COLUMNS)-1:0]   next_col,
   output logic [$clog2(COLUMNS)-1:0]   cell_col,
   output cursor_ctl_type               ctl
);

   localparam int RW  = $clog2(ROWS);
   localparam int CW  = $clog2(COLUMNS);
   localparam int PW  = $clog2(TAB_STOP);
   localparam int CXW = $clog2(COLUMNS + TAB_STOP);

   logic [RW-1:0]  row_ff, row_in;
   logic [CW-1:0]  col_ff, col_in;
   logic [PW-1:0]  phase_ff, phase_in;
   logic [RW:0]    nrow_x;
   logic [RW:0]    row_inc;
   logic [CXW-1:0] tab_x;
   logic [PW-1:0]  nphase;
   logic [CW-1:0]  ncol;

   // The phase register tracks the column modulo the tab stop.
   always_comb begin
      row_inc  = (RW+1)'(row_ff) + (RW+1)'(1);
      tab_x    = CXW'(col_ff) + CXW'(TAB_STOP) - CXW'(phase_ff);
      nrow_x   = (RW+1)'(row_ff);
      ncol     = col_ff;
      nphase   = phase_ff;
      cell_col = col_ff;
      ctl      = '0;
      unique case (char_code)
         CH_NEWLINE: begin
            ncol   = '0;
            nphase = '0;
            nrow_x = row_inc;
         end
         CH_RETURN: begin
            ncol   = '0;
            nphase = '0;
         end
         CH_TAB: begin
            nphase = '0;
            if (tab_x >= CXW'(COLUMNS)) begin
               ncol   = '0;
               nrow_x = row_inc;
            end else begin
               ncol = CW'(tab_x);
            end
         end
         CH_BACKSPACE: begin
            if (col_ff != '0) begin
               ncol      = col_ff - CW'(1);
               cell_col  = col_ff - CW'(1);
               ctl.write = 1'b1;
               ctl.blank = 1'b1;
               nphase    = (phase_ff == '0) ? PW'(TAB_STOP - 1) : phase_ff - PW'(1);
            end
         end
         default: begin
            ctl.write = 1'b1;
            if (col_ff == CW'(COLUMNS - 1)) begin
               ncol   = '0;
               nphase = '0;
               nrow_x = row_inc;
            end else begin
               ncol   = col_ff + CW'(1);
               nphase = (phase_ff == PW'(TAB_STOP - 1)) ? '0 : phase_ff + PW'(1);
            end
         end
      endcase
      ctl.scroll = (nrow_x == (RW+1)'(ROWS));
      next_row   = ctl.scroll ? RW'(ROWS - 1) : nrow_x[RW-1:0];
      next_col   = ncol;
   end

   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      phase_in = phase_ff;
      if (clear_en) begin
         row_in   = '0;
         col_in   = '0;
         phase_in = '0;
      end else if (put_en) begin
         row_in   = next_row;
         col_in   = ncol;
         phase_in = nphase;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         phase_ff <= '0;
      end else begin
         row_ff   <= row_in;
         col_ff   <= col_in;
         phase_ff <= phase_in;
      end
   end

   assign row = row_ff;
   assign col = col_ff;

endmodule

// File: verif/text_console_cell_writer_test.sv
`timescale 1ns / 1ps

module text_console_cell_writer_test;
   import tcw_pkg::*;

   localparam int COLUMNS = 80;
   localparam int ROWS = 25;
   localparam int TAB_STOP = 8;
   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 12_000_000;
   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_BEATS = 350;
   localparam int HOLD_CYCLES = 400;
   localparam int IDLE_PERCENT = 26;

   class console_scoreboard;
      logic [15:0] cells [CELL_COUNT];
      int row;
      int col;
      logic [7:0] color;
      rsp_type expected_reports [$];
      int unsigned mismatches;

      function new();
         int i;
         for (i = 0; i < CELL_COUNT; i++) cells[i] = {RESET_COLOR, BLANK_CHAR};
         row = 0;
         col = 0;
         color = RESET_COLOR;
         mismatches = 0;
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction

      function void set_color(logic [7:0] value);
         color = value;
      endfunction

      function void advance_row();
         col = 0;
         row++;
      endfunction

      function void put_char(logic [7:0] ch);
         int i;
         case (ch)
            CH_NEWLINE: advance_row();
            CH_RETURN: col = 0;
            CH_TAB: begin
               col = col + TAB_STOP - col % TAB_STOP;
               if (col >= COLUMNS) advance_row();
            end
            CH_BACKSPACE: begin
               if (col > 0) begin
                  col--;
                  cells[row * COLUMNS + col] = {color, BLANK_CHAR};
               end
            end
            default: begin
               cells[row * COLUMNS + col] = {color, ch};
               col++;
               if (col >= COLUMNS) advance_row();
            end
         endcase
         if (row >= ROWS) begin
            for (i = 0; i < (ROWS - 1) * COLUMNS; i++) cells[i] = cells[i + COLUMNS];
            for (i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++) cells[i] = {color, BLANK_CHAR};
            row = ROWS - 1;
         end
      endfunction

      function void note_request(req_type beat);
         rsp_type report;
         int i;
         report = '0;
         case (beat.command)
            CMD_PUT: put_char(beat.char_code);
            CMD_CLEAR: begin
               for (i = 0; i < CELL_COUNT; i++) cells[i] = {color, BLANK_CHAR};
               row = 0;
               col = 0;
            end
            CMD_READ: begin
               if (beat.read_row < ROWS && beat.read_col < COLUMNS) begin
                  {report.cell_attr, report.cell_char} =
                     cells[beat.read_row * COLUMNS + beat.read_col];
               end
            end
            default: ;
         endcase
         report.cursor_row = 5'(row);
         report.cursor_col = 7'(col);
         expected_reports.push_back(report);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_reports.size() == 0) begin
            $display("%0t: response beat with none expected: row %0d col %0d char %0d attr %0d",
                     $time, got.cursor_row, got.cursor_col, got.cell_char, got.cell_attr);
            mismatches++;
            return;
         end
         want = expected_reports.pop_front();
         compare_field("cursor_row", want.cursor_row, got.cursor_row);
         compare_field("cursor_col", want.cursor_col, got.cursor_col);
         compare_field("cell_char", want.cell_char, got.cell_char);
         compare_field("cell_attr", want.cell_attr, got.cell_attr);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = 8'h00;

   console_scoreboard sb;
   bit quiet_run = 1'b0;
   int unsigned cycle_count = 0;

   text_console_cell_writer #(
      .COLUMNS(COLUMNS),
      .ROWS(ROWS),
      .TAB_STOP(TAB_STOP)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // The receiver holds off twice for a long stretch so the block backs up.
   initial begin : receiver
      int hold_left;
      int taken;
      hold_left = 0;
      taken = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            sb.check_response(rsp_payload);
            taken++;
            if (taken == 120 || taken == 1300) hold_left = HOLD_CYCLES;
         end
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet_run || $urandom_range(0, 99) >= IDLE_PERCENT;
         end
      end
   end

   function automatic req_type make_beat(logic [1:0] cmd, logic [7:0] ch,
                                         logic [4:0] rr, logic [6:0] rc);
      req_type beat;
      beat.command = cmd;
      beat.char_code = ch;
      beat.read_row = rr;
      beat.read_col = rc;
      return beat;
   endfunction

   task automatic send_beat(input req_type beat);
      while (!quiet_run && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(beat);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_color(input logic [7:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_color(value);
   endtask

   task automatic run_directed();
      send_beat(make_beat(CMD_READ, 8'h00, 5'd0, 7'd0));
      send_beat(make_beat(CMD_READ, 8'hFF, 5'd24, 7'd79));
      send_beat(make_beat(CMD_READ, 8'h00, 5'd25, 7'd0));
      send_beat(make_beat(CMD_READ, 8'h00, 5'd0, 7'd80));
      send_beat(make_beat(CMD_READ, 8'h00, 5'd31, 7'd127));
      send_beat(make_beat(CMD_PUT, 8'h41, 5'd0, 7'd0));
      send_beat(make_beat(CMD_PUT, 8'h00, 5'd31, 7'd127));
      send_beat(make_beat(CMD_PUT, 8'hFF, 5'd0, 7'd0));
      send_beat(make_beat(CMD_PUT, CH_BACKSPACE, 5'd0, 7'd0));
      send_beat(make_beat(CMD_READ, 8'h00, 5'd0, 7'd2));
      send_beat(make_beat(CMD_READ, 8'h00, 5'd0, 7'd1));
      send_beat(make_beat(CMD_PUT, CH_TAB, 5'd0, 7'd0));
      send_beat(make_beat(CMD_PUT, CH_TAB, 5'd0, 7'd0));
      send_beat(make_beat(CMD_PUT, CH_RETURN, 5'd0, 7'd0));
      send_beat(make_beat(CMD_PUT, CH_BACKSPACE, 5'd0, 7'd0));
      send_beat(make_beat(CMD_PUT, CH_NEWLINE, 5'd0, 7'd0));
      send_beat(make_beat(CMD_PUT, 8'h7E, 5'd0, 7'd0));
      send_beat(make_beat(CMD_READ, 8'h00, 5'd1, 7'd0));
      send_beat(make_beat(CMD_UNUSED, 8'hFF, 5'd31, 7'd127));
      send_beat(make_beat(CMD_CLEAR, 8'h00, 5'd0, 7'd0));
      send_beat(make_beat(CMD_READ, 8'h00, 5'd0, 7'd0));
      send_beat(make_beat(CMD_READ, 8'h00, 5'd1, 7'd0));
   endtask

   task automatic send_random(input int count);
      req_type beat;
      int n;
      int pick;
      for (n = 0; n < count; n++) begin
         beat.command = CMD_PUT;
         beat.char_code = 8'($urandom_range(0, 255));
         beat.read_row = 5'($urandom_range(0, 31));
         beat.read_col = 7'($urandom_range(0, 127));
         pick = $urandom_range(0, 999);
         if (pick < 8) begin
            beat.command = CMD_CLEAR;
         end else if (pick < 16) begin
            beat.command = CMD_UNUSED;
         end else if (pick < 150) begin
            beat.command = CMD_READ;
            if (pick < 120) begin
               if (pick < 70) beat.read_row = 5'(sb.row);
               else beat.read_row = 5'($urandom_range(0, ROWS - 1));
               beat.read_col = 7'($urandom_range(0, COLUMNS - 1));
            end
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 7) beat.char_code = CH_NEWLINE;
            else if (pick < 12) beat.char_code = CH_TAB;
            else if (pick < 16) beat.char_code = CH_RETURN;
            else if (pick < 25) beat.char_code = CH_BACKSPACE;
         end
         send_beat(beat);
      end
   endtask

   initial begin : stimulus
      int phase;
      logic [7:0] phase_color;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_responses();
         case (phase)
            0: phase_color = 8'hFF;
            1: phase_color = 8'h00;
            3: phase_color = 8'h80;
            default: phase_color = 8'($urandom_range(0, 255));
         endcase
         quiet_run = (phase == 1);
         write_color(phase_color);
         send_random(PHASE_BEATS);
      end
      drain_responses();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: sim.f
src/tcw_pkg.sv
src/tcw_cursor.sv
src/text_console_cell_writer.sv
verif/text_console_cell_writer_test.sv
